### hdl/sed_pkg.sv
// ----------------------------------------------------------------------------
// sed_pkg
// Types and constants shared by the string escape decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

  localparam int unsigned CharWidth  = 8;
  localparam int unsigned LineWidth  = 16;
  localparam int unsigned OctWidth   = 9;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [CharWidth-1:0] DelimReset  = 8'd34;
  localparam logic [CharWidth-1:0] EscapeReset = 8'd92;
  localparam logic [LineWidth-1:0] LineReset   = 16'd1;

  localparam logic [CharWidth-1:0] ChTab     = 8'd9;
  localparam logic [CharWidth-1:0] ChNewline = 8'd10;
  localparam logic [CharWidth-1:0] ChFormFd  = 8'd12;
  localparam logic [CharWidth-1:0] ChReturn  = 8'd13;
  localparam logic [CharWidth-1:0] ChEsc     = 8'd27;

  typedef enum logic [0:0] {
    REG_DELIMITER = 1'b0,
    REG_ESCAPE    = 1'b1
  } sed_reg_e;

  typedef enum logic [1:0] {
    KIND_CHAR    = 2'd0,
    KIND_EOS     = 2'd1,
    KIND_UNTERM  = 2'd2
  } sed_kind_e;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_ESCAPE = 3'b010,
    MODE_OCTAL  = 3'b100
  } sed_mode_e;

  typedef struct packed {
    sed_kind_e            kind;
    logic [CharWidth-1:0] value;
    logic [LineWidth-1:0] line;
    logic                 last;
  } sed_result_t;

  // Outcome of a character seen in normal mode.
  typedef struct packed {
    logic                 emit;
    logic                 to_escape;
    sed_kind_e            kind;
    logic [CharWidth-1:0] value;
  } sed_normal_t;

endpackage

### hdl/string_escape_decoder.sv
// Results are registered into a result queue when their input word is accepted.
// Throughput: one input word per cycle while two queue entries are free;
// a word that yields two results is absorbed by a four-entry result queue.
// Reset: delimiter 34, escape 92, normal mode, line count 1, queue empty.
// ----------------------------------------------------------------------------
// string_escape_decoder
// Decodes a quoted string literal one raw character per word, yielding
// decoded characters, end-of-string marks and unterminated-string errors.
// ----------------------------------------------------------------------------
module string_escape_decoder
  import sed_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CharWidth-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [CharWidth-1:0] char_in_i,
  input  logic                 end_of_input_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           kind_o,
  output logic [CharWidth-1:0] value_o,
  output logic [LineWidth-1:0] line_number_o,
  output logic                 last_o
);

  logic [CharWidth-1:0] delim_q, escape_q;
  sed_mode_e            mode_q, mode_d;
  logic [OctWidth-1:0]  oval_q, oval_d;
  logic [1:0]           ocnt_q, ocnt_d;
  logic [LineWidth-1:0] line_q, line_d;

  sed_result_t          queue_q [QueueDepth];
  logic [QueuePtrW-1:0] head_q, tail_q;
  logic [QueueCntW-1:0] count_q;

  logic                 in_fire, pop;
  logic                 emit0, emit1;
  sed_kind_e            kind0, kind1;
  logic [CharWidth-1:0] val0, val1;
  logic [1:0]           n_push;
  logic                 is_digit;
  logic [OctWidth-1:0]  oval_n;
  logic [1:0]           ocnt_n;
  sed_normal_t          nr;

  function automatic sed_normal_t normal_step(logic [CharWidth-1:0] c, logic eoi,
                                              logic [CharWidth-1:0] delim,
                                              logic [CharWidth-1:0] esc);
    sed_normal_t r;
    r.emit      = 1'b1;
    r.to_escape = 1'b0;
    r.kind      = KIND_CHAR;
    r.value     = c;
    // The delimiter wins over newline and escape.
    if (!eoi && c == delim) begin
      r.kind  = KIND_EOS;
      r.value = '0;
    end else if (eoi || c == ChNewline) begin
      r.kind  = KIND_UNTERM;
      r.value = '0;
    end else if (c == esc) begin
      r.emit      = 1'b0;
      r.to_escape = 1'b1;
    end
    return r;
  endfunction

  assign in_ready_o = (count_q <= QueueCntW'(QueueDepth - 2));
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign pop        = out_valid_o & out_ready_i;

  assign is_digit = (char_in_i >= "0") && (char_in_i <= "7");
  assign oval_n   = {oval_q[OctWidth-4:0], char_in_i[2:0]};
  assign ocnt_n   = ocnt_q + 2'd1;
  assign nr       = normal_step(char_in_i, end_of_input_i, delim_q, escape_q);

  always_comb begin
    mode_d = mode_q;
    oval_d = oval_q;
    ocnt_d = ocnt_q;
    line_d = line_q;
    emit0  = 1'b0;
    emit1  = 1'b0;
    kind0  = KIND_CHAR;
    kind1  = KIND_CHAR;
    val0   = '0;
    val1   = '0;
    case (mode_q)
      MODE_ESCAPE: begin
        mode_d = MODE_NORMAL;
        emit0  = 1'b1;
        if (end_of_input_i) begin
          kind0 = KIND_EOS;
        end else begin
          case (char_in_i)
            "t":       val0 = ChTab;
            "n":       val0 = ChNewline;
            "f":       val0 = ChFormFd;
            "r":       val0 = ChReturn;
            "e", "p":  val0 = ChEsc;
            ChNewline: begin
              // Line continuation yields nothing.
              emit0  = 1'b0;
              line_d = line_q + LineWidth'(1);
            end
            default: begin
              if (is_digit) begin
                emit0  = 1'b0;
                oval_d = OctWidth'(char_in_i[2:0]);
                ocnt_d = 2'd1;
                mode_d = MODE_OCTAL;
              end else begin
                val0 = char_in_i;
              end
            end
          endcase
        end
      end
      MODE_OCTAL: begin
        if (!end_of_input_i && is_digit) begin
          if (ocnt_n == 2'd3) begin
            emit0  = 1'b1;
            val0   = oval_n[CharWidth-1:0];
            oval_d = '0;
            ocnt_d = '0;
            mode_d = MODE_NORMAL;
          end else begin
            oval_d = oval_n;
            ocnt_d = ocnt_n;
          end
        end else begin
          // Flush the value, then treat this character as a normal one.
          emit0  = 1'b1;
          val0   = oval_q[CharWidth-1:0];
          oval_d = '0;
          ocnt_d = '0;
          emit1  = nr.emit;
          kind1  = nr.kind;
          val1   = nr.value;
          mode_d = nr.to_escape ? MODE_ESCAPE : MODE_NORMAL;
        end
      end
      default: begin
        emit0  = nr.emit;
        kind0  = nr.kind;
        val0   = nr.value;
        mode_d = nr.to_escape ? MODE_ESCAPE : MODE_NORMAL;
      end
    endcase
  end

  assign n_push = in_fire ? ({1'b0, emit0} + {1'b0, emit1}) : 2'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= DelimReset;
      escape_q <= EscapeReset;
      mode_q   <= MODE_NORMAL;
      oval_q   <= '0;
      ocnt_q   <= '0;
      line_q   <= LineReset;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_DELIMITER: delim_q  <= cfg_data_i;
          REG_ESCAPE:    escape_q <= cfg_data_i;
          default:       delim_q  <= delim_q;
        endcase
      end
      if (in_fire) begin
        mode_q <= mode_d;
        oval_q <= oval_d;
        ocnt_q <= ocnt_d;
        line_q <= line_d;
      end
      if (pop) begin
        head_q <= head_q + QueuePtrW'(1);
      end
      tail_q  <= tail_q + QueuePtrW'(n_push);
      count_q <= count_q + QueueCntW'(n_push) - QueueCntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && emit0) begin
      queue_q[tail_q] <= '{kind: kind0, value: val0, line: line_d, last: !emit1};
    end
    if (in_fire && emit1) begin
      queue_q[tail_q + QueuePtrW'(1)] <= '{kind: kind1, value: val1, line: line_d, last: 1'b1};
    end
  end

  assign kind_o        = queue_q[head_q].kind;
  assign value_o       = queue_q[head_q].value;
  assign line_number_o = queue_q[head_q].line;
  assign last_o        = queue_q[head_q].last;

endmodule
